// ===== rtl/lmbph_pkg.sv =====
// Shared types, constants and the log2 fraction table for the level meter.
`timescale 1ns / 1ps

package lmbph_pkg;

    // log2 fraction table: index bits taken below the leading one
    localparam int LOG_FRAC_BITS = 6;
    localparam int LOG_TBL_SIZE  = 1 << LOG_FRAC_BITS;

    // 6.0206 dB per octave in Q.16
    localparam logic signed [19:0] DB_PER_OCTAVE_Q16 = 20'sd394566;

    // register reset values
    localparam logic [15:0]        RISE_COEF_RST   = 16'd25787;
    localparam logic [15:0]        FALL_COEF_RST   = 16'd2570;
    localparam logic [15:0]        HOLD_TICKS_RST  = 16'd150;
    localparam logic [11:0]        DECAY_STEP_RST  = 12'd31;
    localparam logic signed [15:0] FLOOR_LEVEL_RST = -16'sd30720;
    localparam logic [11:0]        CHANGE_THR_RST  = 12'd26;

    typedef enum logic [2:0] {
        REG_RISE_COEF   = 3'd0,
        REG_FALL_COEF   = 3'd1,
        REG_HOLD_TICKS  = 3'd2,
        REG_DECAY_STEP  = 3'd3,
        REG_FLOOR_LEVEL = 3'd4,
        REG_CHANGE_THR  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]        rise_coef;
        logic [15:0]        fall_coef;
        logic [15:0]        hold_ticks;
        logic [11:0]        decay_step;
        logic signed [15:0] floor_level;
        logic [11:0]        change_thr;
    } cfg_t;

    typedef logic [15:0] log_tbl_t [LOG_TBL_SIZE];

    // log2(1 + k/2^LOG_FRAC_BITS) in Q0.16, by repeated squaring; elaboration only
    function automatic log_tbl_t build_log_tbl();
        log_tbl_t    tbl;
        logic [63:0] x;
        logic [19:0] r;
        for (int k = 0; k < LOG_TBL_SIZE; k++) begin
            x = (64'd1 << 30) + ((64'(k) << 30) >> LOG_FRAC_BITS);
            r = '0;
            for (int i = 0; i < 18; i++) begin
                x = (x * x) >> 30;
                r = r << 1;
                if (x >= (64'd2 << 30)) begin
                    x    = x >> 1;
                    r[0] = 1'b1;
                end
            end
            tbl[k] = 16'((r + 20'd2) >> 2);
        end
        return tbl;
    endfunction

    localparam log_tbl_t LOG_TBL = build_log_tbl();

endpackage

// ===== rtl/lmbph_log_db.sv =====
// Gain to dB conversion pipeline: leading one, fraction table, scale, round and floor clamp.
`timescale 1ns / 1ps

module lmbph_log_db #(
    parameter int GAIN_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lmbph_pkg::cfg_t          cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [GAIN_BITS-1:0]     in_gain,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [15:0]       out_target
);
    import lmbph_pkg::*;

    localparam int NSTG   = 5;
    localparam int PW     = $clog2(GAIN_BITS);
    localparam int IW     = PW + 1;
    localparam int LG_W   = IW + 16;
    localparam int PROD_W = LG_W + 20;
    localparam int RND_W  = PROD_W + 1;
    localparam int DB_W   = RND_W - 24;
    localparam logic [RND_W-1:0] HALF = RND_W'(1) << 23;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    logic [GAIN_BITS-1:0]      gain0_reg;
    logic [GAIN_BITS-1:0]      gain1_reg;
    logic [PW-1:0]             pos1_reg;
    logic                      zero1_reg;
    logic signed [LG_W-1:0]    lg2_reg;
    logic                      zero2_reg;
    logic signed [PROD_W-1:0]  prod3_reg;
    logic                      zero3_reg;
    logic signed [15:0]        target4_reg;

    logic [PW-1:0]             pos;
    logic [PW-1:0]             shamt;
    logic [GAIN_BITS-1:0]      norm;
    logic [LOG_FRAC_BITS-1:0]  frac_idx;
    logic [IW-1:0]             ipart;
    logic signed [LG_W-1:0]    lg;
    logic signed [PROD_W-1:0]  prod;
    logic signed [RND_W-1:0]   rsum;
    logic signed [RND_W-1:0]   rshr;
    logic signed [DB_W-1:0]    db;
    logic signed [DB_W-1:0]    floor_ext;
    logic signed [15:0]        target;

    // ready ripples back from the output through empty stages
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready   = en[0];
    assign out_valid  = vld_reg[NSTG-1];
    assign out_target = target4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: leading one
    always_comb begin
        pos = '0;
        for (int i = 0; i < GAIN_BITS; i++) begin
            if (gain0_reg[i]) begin
                pos = PW'(i);
            end
        end
    end

    // stage 2: normalise, table lookup, integer part of log2
    always_comb begin
        shamt    = PW'(GAIN_BITS - 1) - pos1_reg;
        norm     = gain1_reg << shamt;
        frac_idx = norm[GAIN_BITS-2 -: LOG_FRAC_BITS];
        ipart    = IW'({1'b0, pos1_reg}) - IW'(GAIN_BITS - 2);
        lg       = {ipart, 16'h0000} + LG_W'(LOG_TBL[frac_idx]);
    end

    // stage 3: scale to dB
    assign prod = lg2_reg * DB_PER_OCTAVE_Q16;

    // stage 4: round half away from zero, clamp at floor
    always_comb begin
        rsum      = {prod3_reg[PROD_W-1], prod3_reg} + HALF - RND_W'(prod3_reg[PROD_W-1]);
        rshr      = rsum >>> 24;
        db        = rshr[DB_W-1:0];
        floor_ext = {{(DB_W-16){cfg.floor_level[15]}}, cfg.floor_level};
        if (zero3_reg || (db < floor_ext)) begin
            target = cfg.floor_level;
        end else begin
            target = db[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            gain0_reg <= in_gain;
        end
        if (en[1]) begin
            gain1_reg <= gain0_reg;
            pos1_reg  <= pos;
            zero1_reg <= (gain0_reg == '0);
        end
        if (en[2]) begin
            lg2_reg   <= lg;
            zero2_reg <= zero1_reg;
        end
        if (en[3]) begin
            prod3_reg <= prod;
            zero3_reg <= zero2_reg;
        end
        if (en[4]) begin
            target4_reg <= target;
        end
    end

endmodule

// ===== rtl/lmbph_ballistics.sv =====
// Level filter, peak hold and decay, change detect and the result register.
`timescale 1ns / 1ps

module lmbph_ballistics (
    input  logic               aclk,
    input  logic               aresetn,
    input  lmbph_pkg::cfg_t    cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] in_target,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_level,
    output logic signed [15:0] out_peak,
    output logic               out_changed
);
    import lmbph_pkg::*;

    localparam logic [34:0] HALF16 = 35'd32768;

    logic vlvl_reg, vpk_reg, vout_reg;
    logic en_lvl, en_pk, en_out;

    logic signed [15:0] level_reg;
    logic signed [15:0] level_next;
    logic signed [15:0] lvl_pk_reg;
    logic signed [15:0] peak_reg;
    logic signed [15:0] peak_next;
    logic [15:0]        hold_reg;
    logic [15:0]        hold_next;
    logic signed [15:0] shown_lvl_reg;
    logic signed [15:0] shown_pk_reg;
    logic signed [15:0] lvl_out_reg;
    logic signed [15:0] pk_out_reg;
    logic               chg_out_reg;

    logic [15:0]        coef;
    logic signed [16:0] diff;
    logic signed [33:0] fprod;
    logic signed [34:0] fsum;
    logic signed [34:0] fstep;
    logic signed [16:0] dec_pk;
    logic signed [16:0] floor17;
    logic signed [16:0] dl;
    logic signed [16:0] dp;
    logic [16:0]        adl;
    logic [16:0]        adp;
    logic               chg;

    assign en_out   = !vout_reg || out_ready;
    assign en_pk    = !vpk_reg || en_out;
    assign en_lvl   = !vlvl_reg || en_pk;
    assign in_ready = en_lvl;

    assign out_valid   = vout_reg;
    assign out_level   = lvl_out_reg;
    assign out_peak    = pk_out_reg;
    assign out_changed = chg_out_reg;

    // one-pole step: level += round(coef * (target - level) / 2^16)
    always_comb begin
        coef       = (in_target > level_reg) ? cfg.rise_coef : cfg.fall_coef;
        diff       = {in_target[15], in_target} - {level_reg[15], level_reg};
        fprod      = $signed({1'b0, coef}) * diff;
        fsum       = {fprod[33], fprod} + HALF16 - 35'(fprod[33]);
        fstep      = fsum >>> 16;
        level_next = level_reg + fstep[15:0];
    end

    // peak follows, holds, then decays to the floor
    always_comb begin
        floor17   = {cfg.floor_level[15], cfg.floor_level};
        dec_pk    = {peak_reg[15], peak_reg} - {5'b00000, cfg.decay_step};
        peak_next = peak_reg;
        hold_next = hold_reg;
        if (level_reg > peak_reg) begin
            peak_next = level_reg;
            hold_next = cfg.hold_ticks;
        end else if (hold_reg != '0) begin
            hold_next = hold_reg - 16'd1;
        end else if (dec_pk < floor17) begin
            peak_next = cfg.floor_level;
        end else begin
            peak_next = dec_pk[15:0];
        end
    end

    // movement since the last flagged beat
    always_comb begin
        dl  = {lvl_pk_reg[15], lvl_pk_reg} - {shown_lvl_reg[15], shown_lvl_reg};
        dp  = {peak_reg[15], peak_reg} - {shown_pk_reg[15], shown_pk_reg};
        adl = dl[16] ? 17'(-dl) : 17'(dl);
        adp = dp[16] ? 17'(-dp) : 17'(dp);
        chg = (adl > {5'b00000, cfg.change_thr}) || (adp > {5'b00000, cfg.change_thr});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlvl_reg      <= 1'b0;
            vpk_reg       <= 1'b0;
            vout_reg      <= 1'b0;
            level_reg     <= FLOOR_LEVEL_RST;
            peak_reg      <= FLOOR_LEVEL_RST;
            hold_reg      <= '0;
            shown_lvl_reg <= FLOOR_LEVEL_RST;
            shown_pk_reg  <= FLOOR_LEVEL_RST;
        end else begin
            if (en_lvl) begin
                vlvl_reg <= in_valid;
                if (in_valid) begin
                    level_reg <= level_next;
                end
            end
            // peak and hold state live in the peak stage
            if (en_pk) begin
                vpk_reg <= vlvl_reg;
                if (vlvl_reg) begin
                    peak_reg <= peak_next;
                    hold_reg <= hold_next;
                end
            end
            if (en_out) begin
                vout_reg <= vpk_reg;
                if (vpk_reg && chg) begin
                    shown_lvl_reg <= lvl_pk_reg;
                    shown_pk_reg  <= peak_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_pk) begin
            lvl_pk_reg <= level_reg;
        end
        if (en_out) begin
            lvl_out_reg <= lvl_pk_reg;
            pk_out_reg  <= peak_reg;
            chg_out_reg <= chg;
        end
    end

endmodule

// ===== rtl/level_meter_ballistics_peak_hold.sv =====
// Top level: APB register bank, dB conversion pipeline and meter ballistics.
//
//  port group    dir  payload                                beat
//  s_axis        in   s_tdata: gain                          s_tvalid & s_tready
//  m_axis        out  m_tdata: level_db, peak_db; m_tuser    m_tvalid & m_tready
//  apb           in   rise/fall coef, hold, decay, floor,    psel & penable & pwrite
//                     change threshold at 4*i
//
// One beat per cycle sustained while m_tready is high; a result leaves eight register stages after its input beat.
// The throughput bound is the level filter loop: compare, one 17x17 multiply and add per cycle.
// Reset is synchronous: config returns to defaults, level, peak and shown values to -120 dB.
// m_tready low backs up stage by stage; empty stages keep taking beats until the pipe is full.
`timescale 1ns / 1ps

module level_meter_ballistics_peak_hold #(
    parameter int GAIN_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // gain
    input  logic [((GAIN_BITS+7)/8)*8-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // level_db [15:0], peak_db [31:16]
    output logic [31:0]                       m_tdata,
    // changed
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lmbph_pkg::*;

    cfg_t               cfg_reg;
    logic               wr_en;
    reg_idx_t           reg_idx;

    logic               tgt_valid;
    logic               tgt_ready;
    logic signed [15:0] tgt;
    logic signed [15:0] level_db;
    logic signed [15:0] peak_db;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise_coef   <= RISE_COEF_RST;
            cfg_reg.fall_coef   <= FALL_COEF_RST;
            cfg_reg.hold_ticks  <= HOLD_TICKS_RST;
            cfg_reg.decay_step  <= DECAY_STEP_RST;
            cfg_reg.floor_level <= FLOOR_LEVEL_RST;
            cfg_reg.change_thr  <= CHANGE_THR_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RISE_COEF:   cfg_reg.rise_coef   <= pwdata[15:0];
                REG_FALL_COEF:   cfg_reg.fall_coef   <= pwdata[15:0];
                REG_HOLD_TICKS:  cfg_reg.hold_ticks  <= pwdata[15:0];
                REG_DECAY_STEP:  cfg_reg.decay_step  <= pwdata[11:0];
                REG_FLOOR_LEVEL: cfg_reg.floor_level <= pwdata[15:0];
                REG_CHANGE_THR:  cfg_reg.change_thr  <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RISE_COEF:   prdata = {16'h0000, cfg_reg.rise_coef};
            REG_FALL_COEF:   prdata = {16'h0000, cfg_reg.fall_coef};
            REG_HOLD_TICKS:  prdata = {16'h0000, cfg_reg.hold_ticks};
            REG_DECAY_STEP:  prdata = {20'h00000, cfg_reg.decay_step};
            REG_FLOOR_LEVEL: prdata = {16'h0000, cfg_reg.floor_level};
            REG_CHANGE_THR:  prdata = {20'h00000, cfg_reg.change_thr};
            default:         prdata = '0;
        endcase
    end

    lmbph_log_db #(
        .GAIN_BITS (GAIN_BITS)
    ) u_log_db (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_gain    (s_tdata[GAIN_BITS-1:0]),
        .out_valid  (tgt_valid),
        .out_ready  (tgt_ready),
        .out_target (tgt)
    );

    lmbph_ballistics u_ballistics (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (tgt_valid),
        .in_ready    (tgt_ready),
        .in_target   (tgt),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_level   (level_db),
        .out_peak    (peak_db),
        .out_changed (m_tuser)
    );

    assign m_tdata = {peak_db, level_db};

endmodule
